// File: hdl/lfe_pkg.sv
// Shared types and constants for the x86 lazy flag evaluator.
// No dependencies; every other file in hdl/ refers to this package.
`timescale 1ns / 1ps

package lfe_pkg;

  localparam int unsigned DataW = 64;

  typedef logic [DataW-1:0] word_t;

  typedef enum logic [2:0] {
    KIND_ADD   = 3'd0,
    KIND_ADC   = 3'd1,
    KIND_SUB   = 3'd2,
    KIND_SBB   = 3'd3,
    KIND_NEG   = 3'd4,
    KIND_INC   = 3'd5,
    KIND_DEC   = 3'd6,
    KIND_LOGIC = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    SIZE_8  = 2'd0,
    SIZE_16 = 2'd1,
    SIZE_32 = 2'd2,
    SIZE_64 = 2'd3
  } size_sel_t;

  // Stage 1 -> stage 2: operands cut to the operand size.
  typedef struct packed {
    logic  valid;
    kind_t kind;
    word_t a;
    word_t b;
    word_t r;
    word_t m;   // size mask
    word_t sb;  // sign bit at size
  } mask_stage_t;

  // Stage 2 -> stage 3: compare and bit-test results.
  typedef struct packed {
    logic  valid;
    kind_t kind;
    logic  r_lt_a;
    logic  r_eq_a;
    logic  a_lt_b;
    logic  a_lt_r;
    logic  b_full;
    logic  r_zero;
    logic  r_is_sb;
    logic  r_is_sbm1;
    logic  nib_zero;
    logic  nib_full;
    logic  par;
    logic  aux_x;
    logic  of_add;
    logic  of_sub;
    logic  sign;
  } cmp_stage_t;

  function automatic word_t size_mask(input logic [1:0] sz);
    word_t m;
    begin
      unique case (size_sel_t'(sz))
        SIZE_8:  m = word_t'(64'h0000_0000_0000_00ff);
        SIZE_16: m = word_t'(64'h0000_0000_0000_ffff);
        SIZE_32: m = word_t'(64'h0000_0000_ffff_ffff);
        default: m = word_t'(64'hffff_ffff_ffff_ffff);
      endcase
      return m;
    end
  endfunction

  function automatic word_t size_sign(input logic [1:0] sz);
    word_t s;
    begin
      unique case (size_sel_t'(sz))
        SIZE_8:  s = word_t'(64'h0000_0000_0000_0080);
        SIZE_16: s = word_t'(64'h0000_0000_0000_8000);
        SIZE_32: s = word_t'(64'h0000_0000_8000_0000);
        default: s = word_t'(64'h8000_0000_0000_0000);
      endcase
      return s;
    end
  endfunction

endpackage

// File: hdl/x86_lazy_flag_evaluator_unit.sv
// Top level of the x86 lazy flag evaluator: three-stage flag pipeline.
// Depends on lfe_pkg, lfe_mask, lfe_cmp and lfe_sel.
`timescale 1ns / 1ps

// Computes CF, PF, AF, ZF, SF, OF for one recorded x86 ALU operation per
// transaction. A transaction is taken on any cycle where start is high; busy
// is always low, so one record can enter every clock. Each result is marked
// by done for one cycle, in input order. The pipeline is mask, compare,
// select, each stage registered; the 64-bit magnitude compares in the
// middle stage set the clock. Results must be captured when done is high.
module x86_lazy_flag_evaluator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd,
  input  logic [1:0]  size,
  input  logic [63:0] op1,
  input  logic [63:0] op2,
  input  logic [63:0] res,
  output logic        done,
  output logic        cf,
  output logic        pf,
  output logic        af,
  output logic        zf,
  output logic        sf,
  output logic        of,
  output logic        cf_defined
);

  lfe_pkg::mask_stage_t s1;
  lfe_pkg::cmp_stage_t  s2;

  assign busy = 1'b0;

  lfe_mask u_mask (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start & ~busy),
    .cmd      (cmd),
    .size     (size),
    .op1      (op1),
    .op2      (op2),
    .res      (res),
    .st       (s1)
  );

  lfe_cmp u_cmp (
    .clk (clk),
    .rst (rst),
    .si  (s1),
    .so  (s2)
  );

  lfe_sel u_sel (
    .clk        (clk),
    .rst        (rst),
    .si         (s2),
    .done       (done),
    .cf         (cf),
    .pf         (pf),
    .af         (af),
    .zf         (zf),
    .sf         (sf),
    .of         (of),
    .cf_defined (cf_defined)
  );

endmodule

// File: hdl/lfe_mask.sv
// Stage 1: cuts operands and result to the operand size.
// Depends on lfe_pkg.
`timescale 1ns / 1ps

module lfe_mask (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [2:0]         cmd,
  input  logic [1:0]         size,
  input  lfe_pkg::word_t     op1,
  input  lfe_pkg::word_t     op2,
  input  lfe_pkg::word_t     res,
  output lfe_pkg::mask_stage_t st
);

  lfe_pkg::word_t m;

  assign m = lfe_pkg::size_mask(size);

  always_ff @(posedge clk) begin
    if (rst) begin
      st.valid <= 1'b0;
    end else begin
      st.valid <= in_valid;
    end
    st.kind <= lfe_pkg::kind_t'(cmd);
    st.a    <= op1 & m;
    st.b    <= op2 & m;
    st.r    <= res & m;
    st.m    <= m;
    st.sb   <= lfe_pkg::size_sign(size);
  end

endmodule

// File: hdl/lfe_cmp.sv
// Stage 2: magnitude compares, equality tests, parity and overflow terms.
// Depends on lfe_pkg; fed by lfe_mask.
`timescale 1ns / 1ps

module lfe_cmp (
  input  logic                  clk,
  input  logic                  rst,
  input  lfe_pkg::mask_stage_t  si,
  output lfe_pkg::cmp_stage_t   so
);

  lfe_pkg::word_t axb;
  lfe_pkg::word_t axr;

  assign axb = si.a ^ si.b;
  assign axr = si.a ^ si.r;

  always_ff @(posedge clk) begin
    if (rst) begin
      so.valid <= 1'b0;
    end else begin
      so.valid <= si.valid;
    end
    so.kind      <= si.kind;
    so.r_lt_a    <= si.r < si.a;
    so.r_eq_a    <= si.r == si.a;
    so.a_lt_b    <= si.a < si.b;
    so.a_lt_r    <= si.a < si.r;
    so.b_full    <= si.b == si.m;
    so.r_zero    <= si.r == '0;
    so.r_is_sb   <= si.r == si.sb;
    so.r_is_sbm1 <= si.r == (si.sb - lfe_pkg::word_t'(1));
    so.nib_zero  <= si.r[3:0] == 4'h0;
    so.nib_full  <= si.r[3:0] == 4'hf;
    so.par       <= ~^si.r[7:0];
    so.aux_x     <= axb[4] ^ si.r[4];
    so.of_add    <= |(~axb & axr & si.sb);
    so.of_sub    <= |(axb & axr & si.sb);
    so.sign      <= |(si.r & si.sb);
  end

endmodule

// File: hdl/lfe_sel.sv
// Stage 3: picks the flag formulas for the operation kind, drives the outputs.
// Depends on lfe_pkg; fed by lfe_cmp.
`timescale 1ns / 1ps

module lfe_sel (
  input  logic                 clk,
  input  logic                 rst,
  input  lfe_pkg::cmp_stage_t  si,
  output logic                 done,
  output logic                 cf,
  output logic                 pf,
  output logic                 af,
  output logic                 zf,
  output logic                 sf,
  output logic                 of,
  output logic                 cf_defined
);

  logic cf_next;
  logic af_next;
  logic of_next;
  logic cfd_next;

  always_comb begin
    cf_next  = 1'b0;
    af_next  = 1'b0;
    of_next  = 1'b0;
    cfd_next = 1'b1;
    unique case (si.kind)
      lfe_pkg::KIND_ADD: begin
        cf_next = si.r_lt_a;
        af_next = si.aux_x;
        of_next = si.of_add;
      end
      lfe_pkg::KIND_ADC: begin
        // carry in assumed one
        cf_next = si.r_lt_a | si.r_eq_a;
        af_next = si.aux_x;
        of_next = si.of_add;
      end
      lfe_pkg::KIND_SUB: begin
        cf_next = si.a_lt_b;
        af_next = si.aux_x;
        of_next = si.of_sub;
      end
      lfe_pkg::KIND_SBB: begin
        cf_next = si.a_lt_r | si.b_full;
        af_next = si.aux_x;
        of_next = si.of_sub;
      end
      lfe_pkg::KIND_NEG: begin
        cf_next = ~si.r_zero;
        af_next = ~si.nib_zero;
        of_next = si.r_is_sb;
      end
      lfe_pkg::KIND_INC: begin
        cfd_next = 1'b0;
        af_next  = si.nib_zero;
        of_next  = si.r_is_sb;
      end
      lfe_pkg::KIND_DEC: begin
        cfd_next = 1'b0;
        af_next  = si.nib_full;
        of_next  = si.r_is_sbm1;
      end
      lfe_pkg::KIND_LOGIC: begin
        cf_next = 1'b0;
      end
      default: begin
        cf_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= si.valid;
    end
    cf         <= cf_next;
    pf         <= si.par;
    af         <= af_next;
    zf         <= si.r_zero;
    sf         <= si.sign;
    of         <= of_next;
    cf_defined <= cfd_next;
  end

endmodule
